// ===== rtl/core/cnv_pkg.sv =====
`timescale 1ns / 1ps

package cnv_pkg;

    // default configuration
    localparam int DEF_MAX_LEN     = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int OUT_W     = 32;
    localparam int STAT_W    = 2;
    localparam int FRAC_BITS = 15;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND_FIRST  = 2'd0,
        ACT_APPEND_SECOND = 2'd1,
        ACT_QUERY         = 2'd2,
        ACT_CLEAR         = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

// ===== rtl/core/cnv_mem.sv =====
`timescale 1ns / 1ps

module cnv_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/core/cnv_mac.sv =====
`timescale 1ns / 1ps

module cnv_mac
    import cnv_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int CNT_W       = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_h,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic                          o_pending,
    output logic signed [OUT_W-1:0]       o_value
);

    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int ACC_W = PW + CNT_W;
    localparam int SAT_W = (ACC_W > 47) ? ACC_W : 48;

    localparam logic signed [SAT_W-1:0] MAX_V = SAT_W'(signed'(33'h0_7FFF_FFFF));
    localparam logic signed [SAT_W-1:0] MIN_V = SAT_W'(signed'(33'h1_8000_0000));

    logic signed [PW-1:0]    r_prod;
    logic                    r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SAT_W-1:0] acc_ext;
    logic signed [SAT_W-1:0] acc_sh;

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else if (i_ctl.clear) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.valid;
            if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_h * i_x;
    end

    // floor shift the q13.30 sum (default widths) by FRAC_BITS and clamp to 32 bits
    assign acc_ext = SAT_W'(r_acc);
    assign acc_sh  = acc_ext >>> FRAC_BITS;

    always_comb begin
        if (acc_sh > MAX_V) begin
            o_value = MAX_V[OUT_W-1:0];
        end else if (acc_sh < MIN_V) begin
            o_value = MIN_V[OUT_W-1:0];
        end else begin
            o_value = acc_sh[OUT_W-1:0];
        end
    end

    assign o_pending = r_pv;

endmodule

// ===== rtl/core/centered_linear_convolution_top.sv =====
`timescale 1ns / 1ps

// channel   direction  ports                                          handshake
// command   in         i_action, i_sample_value, i_result_index       start / busy
// result    out        o_out_value, o_out_length, o_status            o_valid strobe
//
// appends, clears and failed queries are accepted while idle, the result word follows
// in the next cycle and busy stays low, so such words may come in every cycle
// a query that passes its checks sweeps the response taps: one memory read of each
// array per response tap, a product register, the accumulator and the final clamp;
// the single multiply-accumulate unit and one read port per memory take taps in turn
// synchronous active-low reset clears counts and control; memory contents are kept
// the receiver cannot stall: o_valid marks each result word for one cycle only

module centered_linear_convolution_top
    import cnv_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ACT_W-1:0]              i_action,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [IDX_W-1:0]              i_result_index,
    output logic                          o_valid,
    output logic signed [OUT_W-1:0]       o_out_value,
    output logic [LEN_W-1:0]              o_out_length,
    output logic [STAT_W-1:0]             o_status
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    // wide enough for n + mid and for the most negative tap offset
    localparam int JW    = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt1;
    logic [CNT_W-1:0]        r_cnt2;
    logic [CNT_W-1:0]        r_lh;
    logic [CNT_W-1:0]        r_lx;
    logic                    r_hf;      // response lives in the first array
    logic [CNT_W-1:0]        r_k;       // response tap being read
    logic signed [JW-1:0]    r_j;       // signal index n + mid - k
    logic                    r_p1;      // read in flight
    logic                    r_v1;      // read in flight lands inside the signal

    logic                    accept;
    t_action                 act;
    logic                    full1;
    logic                    full2;
    logic                    we1;
    logic                    we2;
    logic                    q_hf;
    logic [CNT_W-1:0]        q_lh;
    logic [CNT_W-1:0]        q_lx;
    logic                    q_empty;
    logic                    q_range;
    logic                    q_go;
    logic                    issue;
    logic                    j_in;
    logic [AW-1:0]           k_addr;
    logic [AW-1:0]           j_addr;
    logic [AW-1:0]           raddr1;
    logic [AW-1:0]           raddr2;
    logic [SAMPLE_BITS-1:0]  rdata1;
    logic [SAMPLE_BITS-1:0]  rdata2;
    t_mac_ctl                mac_ctl;
    logic                    mac_pending;
    logic signed [OUT_W-1:0] mac_value;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign act    = t_action'(i_action);

    // append path: write at the fill count unless the array is full
    assign full1 = (r_cnt1 == CNT_W'(MAX_LEN));
    assign full2 = (r_cnt2 == CNT_W'(MAX_LEN));
    assign we1   = accept && (act == ACT_APPEND_FIRST) && !full1;
    assign we2   = accept && (act == ACT_APPEND_SECOND) && !full2;

    // query checks: shorter array is the response, second one on a tie
    assign q_hf    = (r_cnt2 > r_cnt1);
    assign q_lh    = q_hf ? r_cnt1 : r_cnt2;
    assign q_lx    = q_hf ? r_cnt2 : r_cnt1;
    assign q_empty = (r_cnt1 == '0) || (r_cnt2 == '0);
    assign q_range = (JW'(i_result_index) >= JW'(q_lx));
    assign q_go    = accept && (act == ACT_QUERY) && !q_empty && !q_range;

    // tap sweep: one response tap per cycle, taps off the signal ends are skipped
    assign issue  = (r_state == S_RUN) && (r_k != r_lh);
    assign j_in   = !r_j[JW-1] && (r_j[JW-2:0] < (JW-1)'(r_lx));
    assign k_addr = r_k[AW-1:0];
    assign j_addr = r_j[AW-1:0];
    assign raddr1 = r_hf ? k_addr : j_addr;
    assign raddr2 = r_hf ? j_addr : k_addr;

    assign mac_ctl.clear = q_go;
    assign mac_ctl.valid = r_p1 && r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_p1    <= 1'b0;
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_p1 <= 1'b0;
                    if (accept) begin
                        o_out_value  <= '0;
                        o_out_length <= '0;
                        o_status     <= ST_OK;
                        unique case (act)
                            ACT_APPEND_FIRST: begin
                                o_valid <= 1'b1;
                                if (full1) begin
                                    o_status <= ST_FULL;
                                end else begin
                                    r_cnt1 <= r_cnt1 + 1'b1;
                                end
                            end
                            ACT_APPEND_SECOND: begin
                                o_valid <= 1'b1;
                                if (full2) begin
                                    o_status <= ST_FULL;
                                end else begin
                                    r_cnt2 <= r_cnt2 + 1'b1;
                                end
                            end
                            ACT_QUERY: begin
                                r_hf <= q_hf;
                                r_lh <= q_lh;
                                r_lx <= q_lx;
                                r_k  <= '0;
                                r_j  <= JW'(i_result_index) + JW'(q_lh >> 1);
                                if (q_empty) begin
                                    o_valid  <= 1'b1;
                                    o_status <= ST_EMPTY;
                                end else if (q_range) begin
                                    o_valid      <= 1'b1;
                                    o_status     <= ST_RANGE;
                                    o_out_length <= LEN_W'(q_lx);
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                            ACT_CLEAR: begin
                                o_valid <= 1'b1;
                                r_cnt1  <= '0;
                                r_cnt2  <= '0;
                            end
                            default: begin
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_p1 <= issue;
                    r_v1 <= j_in;
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                        r_j <= r_j - JW'(1);
                    end else if (!r_p1 && !mac_pending) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_valid      <= 1'b1;
                    o_out_value  <= mac_value;
                    o_out_length <= LEN_W'(r_lx);
                    o_status     <= ST_OK;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    cnv_mem #(
        .DEPTH (MAX_LEN),
        .WIDTH (SAMPLE_BITS)
    ) u_first (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_cnt1[AW-1:0]),
        .i_wdata (i_sample_value),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    cnv_mem #(
        .DEPTH (MAX_LEN),
        .WIDTH (SAMPLE_BITS)
    ) u_second (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_cnt2[AW-1:0]),
        .i_wdata (i_sample_value),
        .i_raddr (raddr2),
        .o_rdata (rdata2)
    );

    cnv_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_h       (r_hf ? signed'(rdata1) : signed'(rdata2)),
        .i_x       (r_hf ? signed'(rdata2) : signed'(rdata1)),
        .o_pending (mac_pending),
        .o_value   (mac_value)
    );

`ifndef ASSERT_OFF
    // fill counts never pass the array depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt1 <= CNT_W'(MAX_LEN)) && (r_cnt2 <= CNT_W'(MAX_LEN)))
        else $error("fill count beyond array depth");

    // tap counter never runs past the response length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= r_lh))
        else $error("tap counter overran response");

    // a finished query hands back its word and frees the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_valid && !busy && (o_status == ST_OK)))
        else $error("query result word missing");

    // nothing reaches the accumulator once the sweep has drained
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (!r_p1 && !mac_pending))
        else $error("accumulator still busy at result");
`endif

endmodule
